@@ hdl/alist_pkg.sv @@
// ============================================================================
// alist_pkg: shared types and constants for the array list engine
// Field widths, operation codes, cell control struct and read tree shape.
// ============================================================================
package alist_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 128;
    localparam int unsigned DATA_W           = 32;
    localparam int unsigned POS_W            = 7;
    localparam int unsigned COUNT_W          = 8;
    localparam int unsigned OP_W             = 3;

    // read tree: fan-in per level and registered levels (covers 16**3 cells)
    localparam int unsigned TREE_GROUP = 16;
    localparam int unsigned TREE_LAT   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_OVERWRITE = 3'd1,
        OP_DROP      = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_READ      = 3'd4,
        OP_SWAP      = 3'd5
    } alist_op_t;

    typedef struct packed {
        logic shift;
        logic wr_a;
        logic wr_b;
    } alist_ctl_t;

endpackage

@@ hdl/alist_req_if.sv @@
// ============================================================================
// alist_req_if: request channel
// Valid/ready handshake carrying one list operation item.
// ============================================================================
interface alist_req_if;
    import alist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position_a;
    logic [POS_W-1:0]         position_b;
    logic signed [DATA_W-1:0] value;

    modport source (
        output valid,
        output operation,
        output position_a,
        output position_b,
        output value,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  position_a,
        input  position_b,
        input  value,
        output ready
    );

endinterface

@@ hdl/alist_rsp_if.sv @@
// ============================================================================
// alist_rsp_if: response channel
// Valid/ready handshake carrying one result item per request.
// ============================================================================
interface alist_rsp_if;
    import alist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;

    modport source (
        output valid,
        output ok,
        output read_value,
        output count,
        input  ready
    );

    modport sink (
        input  valid,
        input  ok,
        input  read_value,
        input  count,
        output ready
    );

endinterface

@@ hdl/array_list_engine.sv @@
// ============================================================================
// array_list_engine: bounded ordered list of signed words
// Append, overwrite, drop last, remove with close-up, read and swap, each
// answered with a success flag, read data and the element count.
// ============================================================================
// The list lives in a row of CAPACITY cells, one word each; a remove shifts
// every cell at or above the position down by one, all cells at once. Append,
// overwrite, drop and remove step through accept, execute and hand-off
// to the output register, and so does a refused read or swap. A read or swap
// that passes the bounds check adds a fetch step: the selected words come back
// through a three-level registered OR tree over the cells, and a swap writes
// both cells in the cycle the tree answers. The output register holds a
// finished result while the next item is accepted; an item stalls in its
// last step only while an earlier result is still waiting to be taken.
module array_list_engine #(
    parameter int unsigned CAPACITY = alist_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    alist_req_if.sink   req,
    alist_rsp_if.source rsp
);
    import alist_pkg::*;

    localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int unsigned WAIT_W = $clog2(TREE_LAT);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } state_t;

    state_t               state_reg,     state_next;
    logic [OP_W-1:0]      op_reg,        op_next;
    logic [POS_W-1:0]     pa_reg,        pa_next;
    logic [POS_W-1:0]     pb_reg,        pb_next;
    logic [DATA_W-1:0]    val_reg,       val_next;
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic [WAIT_W-1:0]    wait_reg,      wait_next;
    logic                 res_ok_reg,    res_ok_next;
    logic [DATA_W-1:0]    res_rd_reg,    res_rd_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg,    out_ok_next;
    logic [DATA_W-1:0]    out_rd_reg,    out_rd_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    alist_ctl_t           ctl;
    logic [IDX_W-1:0]     pos_a;
    logic [IDX_W-1:0]     pos_b;
    logic [DATA_W-1:0]    wdata_a;
    logic [DATA_W-1:0]    wdata_b;
    logic [DATA_W-1:0]    tree_a;
    logic [DATA_W-1:0]    tree_b;

    logic [DATA_W-1:0]    cell_data [CAPACITY];
    logic [DATA_W-1:0]    upper     [CAPACITY];
    logic [DATA_W-1:0]    tap_a     [CAPACITY];
    logic [DATA_W-1:0]    tap_b     [CAPACITY];

    logic                 pa_in;
    logic                 pb_in;
    logic                 op_ok;

    // ------------------------------------------------------------------
    // Cell row and read trees
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_top
            assign upper[i] = cell_data[i];
        end
        else
        begin : g_mid
            assign upper[i] = cell_data[i + 1];
        end

        alist_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos_a      (pos_a),
            .pos_b      (pos_b),
            .wdata_a    (wdata_a),
            .wdata_b    (wdata_b),
            .upper_data (upper[i]),
            .data       (cell_data[i]),
            .rd_a       (tap_a[i]),
            .rd_b       (tap_b[i])
        );
    end

    alist_or_tree #(.N(CAPACITY)) u_tree_a (
        .clk  (clk),
        .leaf (tap_a),
        .root (tree_a)
    );

    alist_or_tree #(.N(CAPACITY)) u_tree_b (
        .clk  (clk),
        .leaf (tap_b),
        .root (tree_b)
    );

    // ------------------------------------------------------------------
    // Bounds check
    // ------------------------------------------------------------------
    assign pa_in = CMP_W'(pa_reg) < CMP_W'(count_reg);
    assign pb_in = CMP_W'(pb_reg) < CMP_W'(count_reg);

    always_comb
    begin
        case (op_reg)
            OP_APPEND:    op_ok = (count_reg != CNT_FULL);
            OP_OVERWRITE: op_ok = pa_in;
            OP_DROP:      op_ok = (count_reg != '0);
            OP_REMOVE:    op_ok = pa_in;
            OP_READ:      op_ok = pa_in;
            OP_SWAP:      op_ok = pa_in && pb_in;
            default:      op_ok = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Cell commands
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl     = '0;
        pos_a   = IDX_W'(pa_reg);
        pos_b   = IDX_W'(pb_reg);
        wdata_a = val_reg;
        wdata_b = tree_b;
        if ((state_reg == S_EXEC) && op_ok)
        begin
            case (op_reg)
                OP_APPEND:
                begin
                    ctl.wr_a = 1'b1;
                    pos_a    = IDX_W'(count_reg);
                end
                OP_OVERWRITE: ctl.wr_a  = 1'b1;
                OP_REMOVE:    ctl.shift = 1'b1;
                default:      ctl       = '0;
            endcase
        end
        else if ((state_reg == S_FETCH) && (wait_reg == '0) && (op_reg == OP_SWAP))
        begin
            ctl.wr_a = 1'b1;
            ctl.wr_b = 1'b1;
            wdata_a  = tree_b;
            wdata_b  = tree_a;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        res_ok_next    = res_ok_reg;
        res_rd_next    = res_rd_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_rd_next    = out_rd_reg;
        out_count_next = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    pa_next    = req.position_a;
                    pb_next    = req.position_b;
                    val_next   = req.value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_ok_next = op_ok;
                res_rd_next = '0;
                if (op_ok && ((op_reg == OP_READ) || (op_reg == OP_SWAP)))
                begin
                    wait_next  = WAIT_W'(TREE_LAT - 1);
                    state_next = S_FETCH;
                end
                else
                begin
                    if (op_ok && (op_reg == OP_APPEND))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (op_ok && ((op_reg == OP_DROP) || (op_reg == OP_REMOVE)))
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                if (wait_reg == '0)
                begin
                    res_rd_next = (op_reg == OP_READ) ? tree_a : '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_rd_next    = res_rd_reg;
                    out_count_next = COUNT_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
            val_reg       <= '0;
            count_reg     <= '0;
            wait_reg      <= '0;
            res_ok_reg    <= 1'b0;
            res_rd_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pa_reg        <= pa_next;
            pb_reg        <= pb_next;
            val_reg       <= val_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            res_ok_reg    <= res_ok_next;
            res_rd_reg    <= res_rd_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_rd_reg    <= out_rd_next;
            out_count_reg <= out_count_next;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.read_value = out_rd_reg;
    assign rsp.count      = out_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("element count above capacity");

    a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == S_EXEC))
        else $error("element count changed outside execute step");

    a_read_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.read_value != '0)) |-> rsp.ok)
        else $error("nonzero read data on a refused item");

    a_swap_write_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_b) |-> ((op_reg == OP_SWAP) && pa_in && pb_in))
        else $error("swap write outside the list");

endmodule

@@ hdl/alist_cell.sv @@
// ============================================================================
// alist_cell: one list element
// Holds one word; on a shift at or below its index takes its upper neighbor's
// word, else a write to its index. Drives its word onto two masked read taps.
// ============================================================================
module alist_cell #(
    parameter int unsigned IDX_W = 7,
    parameter int unsigned INDEX = 0
) (
    input  logic                          clk,
    input  alist_pkg::alist_ctl_t         ctl,
    input  logic [IDX_W-1:0]              pos_a,
    input  logic [IDX_W-1:0]              pos_b,
    input  logic [alist_pkg::DATA_W-1:0]  wdata_a,
    input  logic [alist_pkg::DATA_W-1:0]  wdata_b,
    input  logic [alist_pkg::DATA_W-1:0]  upper_data,
    output logic [alist_pkg::DATA_W-1:0]  data,
    output logic [alist_pkg::DATA_W-1:0]  rd_a,
    output logic [alist_pkg::DATA_W-1:0]  rd_b
);
    import alist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift && (MY_IDX >= pos_a))
        begin
            data_next = upper_data;
        end
        else if (ctl.wr_a && (MY_IDX == pos_a))
        begin
            data_next = wdata_a;
        end
        else if (ctl.wr_b && (MY_IDX == pos_b))
        begin
            data_next = wdata_b;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign rd_a = (MY_IDX == pos_a) ? data_reg : '0;
    assign rd_b = (MY_IDX == pos_b) ? data_reg : '0;

endmodule

@@ hdl/alist_or_tree.sv @@
// ============================================================================
// alist_or_tree: registered OR tree over the cell read taps
// Three registered levels of up to sixteen inputs each; at most one leaf
// is nonzero, so the root carries the selected word.
// ============================================================================
module alist_or_tree #(
    parameter int unsigned N = 128
) (
    input  logic                          clk,
    input  logic [alist_pkg::DATA_W-1:0]  leaf [N],
    output logic [alist_pkg::DATA_W-1:0]  root
);
    import alist_pkg::*;

    localparam int unsigned G  = TREE_GROUP;
    localparam int unsigned L1 = (N + G - 1) / G;
    localparam int unsigned L2 = (L1 + G - 1) / G;

    logic [DATA_W-1:0] s1_reg  [L1];
    logic [DATA_W-1:0] s1_next [L1];
    logic [DATA_W-1:0] s2_reg  [L2];
    logic [DATA_W-1:0] s2_next [L2];
    logic [DATA_W-1:0] root_reg;
    logic [DATA_W-1:0] root_next;

    always_comb
    begin
        for (int g = 0; g < L1; g++)
        begin
            s1_next[g] = '0;
            for (int j = 0; j < G; j++)
            begin
                if (g * G + j < N)
                begin
                    s1_next[g] = s1_next[g] | leaf[g * G + j];
                end
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < L2; g++)
        begin
            s2_next[g] = '0;
            for (int j = 0; j < G; j++)
            begin
                if (g * G + j < L1)
                begin
                    s2_next[g] = s2_next[g] | s1_reg[g * G + j];
                end
            end
        end
    end

    always_comb
    begin
        root_next = '0;
        for (int j = 0; j < L2; j++)
        begin
            root_next = root_next | s2_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

@@ tb/tb_array_list_engine.sv @@
// ============================================================================
// tb_array_list_engine: self-checking testbench for the array list engine
// Drives list requests through the request channel and checks each result
// item against an in-bench model of the list, which covers contents, count,
// bounds refusals and close-up on remove. Both channels idle at random but for
// a calm stretch of accepted items. The random part alternates between filling
// the list to capacity and draining it back to empty.
// ============================================================================
module tb_array_list_engine;
    import alist_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY     = CAPACITY_DEFAULT;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned TAIL_CYCLES  = 20;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        logic [DATA_W-1:0] value;
        bit                drain_first;
    } list_req_t;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } list_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    alist_req_if req_ch ();
    alist_rsp_if rsp_ch ();

    array_list_engine #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    list_req_t         pending_q[$];
    list_rsp_t         expected_q[$];
    list_req_t         cur_item;
    list_rsp_t         got;
    list_rsp_t         want;

    logic [DATA_W-1:0] list_words [0:CAPACITY-1];
    int unsigned       list_len;
    int unsigned       gen_count;

    int unsigned       accepted_items;
    int unsigned       results_checked;
    int unsigned       refusals;
    int unsigned       peak_count;
    int unsigned       errors;
    logic              calm;

    assign calm = (accepted_items >= 250) && (accepted_items < 400);

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // list model: apply one request, return its result item
    function automatic list_rsp_t apply_list_op(list_req_t r);
        list_rsp_t         res;
        logic [DATA_W-1:0] held;
        res.ok         = 1'b0;
        res.read_value = '0;
        case (alist_op_t'(r.operation))
            OP_APPEND:
                if (list_len < CAPACITY)
                begin
                    list_words[list_len] = r.value;
                    list_len++;
                    res.ok = 1'b1;
                end
            OP_OVERWRITE:
                if (r.pos_a < list_len)
                begin
                    list_words[r.pos_a] = r.value;
                    res.ok = 1'b1;
                end
            OP_DROP:
                if (list_len != 0)
                begin
                    list_len--;
                    res.ok = 1'b1;
                end
            OP_REMOVE:
                if (r.pos_a < list_len)
                begin
                    for (int unsigned i = r.pos_a; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                    res.ok = 1'b1;
                end
            OP_READ:
                if (r.pos_a < list_len)
                begin
                    res.read_value = list_words[r.pos_a];
                    res.ok = 1'b1;
                end
            OP_SWAP:
                if (r.pos_a < list_len && r.pos_b < list_len)
                begin
                    held                = list_words[r.pos_a];
                    list_words[r.pos_a] = list_words[r.pos_b];
                    list_words[r.pos_b] = held;
                    res.ok = 1'b1;
                end
            default: ;
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    // queue one request and track the count it leaves behind
    task automatic queue_item(logic [OP_W-1:0] op, int unsigned pa, int unsigned pb,
                              logic [DATA_W-1:0] val, bit drain_first = 1'b0);
        list_req_t r;
        r.operation   = op;
        r.pos_a       = POS_W'(pa);
        r.pos_b       = POS_W'(pb);
        r.value       = val;
        r.drain_first = drain_first;
        pending_q.push_back(r);
        case (alist_op_t'(op))
            OP_APPEND: if (gen_count < CAPACITY) gen_count++;
            OP_DROP:   if (gen_count != 0) gen_count--;
            OP_REMOVE: if (pa < gen_count) gen_count--;
            default: ;
        endcase
    endtask

    function automatic int unsigned pick_pos(int unsigned cnt);
        if (cnt > 0 && $urandom_range(99) < 85)
            return $urandom_range(cnt - 1);
        return $urandom_range(CAPACITY - 1);
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(39))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.operation  <= '0;
            req_ch.position_a <= '0;
            req_ch.position_b <= '0;
            req_ch.value      <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_q.push_back(apply_list_op(cur_item));
                accepted_items++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() > 0
                    && !(pending_q[0].drain_first && expected_q.size() != 0)
                    && (calm || $urandom_range(99) >= 15))
                begin
                    cur_item = pending_q.pop_front();
                    req_ch.operation  <= cur_item.operation;
                    req_ch.position_a <= cur_item.pos_a;
                    req_ch.position_b <= cur_item.pos_b;
                    req_ch.value      <= cur_item.value;
                    req_ch.valid      <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.ok         = rsp_ch.ok;
                got.read_value = rsp_ch.read_value;
                got.count      = rsp_ch.count;
                if (expected_q.size() == 0)
                begin
                    $error("result item with none expected: ok=%0b read_value=%0d count=%0d",
                           got.ok, got.read_value, got.count);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.ok !== want.ok)
                    begin
                        $error("ok: expected %0b, got %0b", want.ok, got.ok);
                        errors++;
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, got.read_value);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        errors++;
                    end
                    results_checked++;
                    if (!want.ok)
                        refusals++;
                    if (want.count > peak_count)
                        peak_count = 32'(want.count);
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    initial
    begin
        int unsigned       n;
        int unsigned       roll;
        bit                filling;
        logic [OP_W-1:0]   op;

        list_len        = 0;
        gen_count       = 0;
        accepted_items  = 0;
        results_checked = 0;
        refusals        = 0;
        peak_count      = 0;
        errors          = 0;

        // empty list: everything that needs an element is refused; directed cases follow
        queue_item(OP_DROP, 0, 0, '0);
        queue_item(OP_READ, 0, 0, '0);
        queue_item(OP_REMOVE, 0, 0, '0);
        queue_item(OP_SWAP, 0, 0, '0);
        queue_item(OP_OVERWRITE, 0, 0, WORD_MAX);
        queue_item(OP_SPARE_6, 0, 0, '0);
        queue_item(OP_SPARE_7, 127, 127, '1);
        queue_item(OP_APPEND, 0, 0, WORD_MIN);
        queue_item(OP_APPEND, 127, 127, WORD_MAX);
        queue_item(OP_APPEND, 0, 0, '1);
        queue_item(OP_APPEND, 0, 0, '0);
        queue_item(OP_READ, 0, 0, '0);
        queue_item(OP_READ, 1, 0, '0);
        queue_item(OP_OVERWRITE, 1, 0, 32'h5555_5555);
        queue_item(OP_SWAP, 0, 2, '0);
        queue_item(OP_SWAP, 1, 1, '0);
        queue_item(OP_SWAP, 0, 4, '0);
        queue_item(OP_READ, 4, 0, '0);
        queue_item(OP_REMOVE, 0, 0, '0);
        queue_item(OP_READ, 0, 0, '0);
        queue_item(OP_READ, 127, 0, '0);
        queue_item(OP_SPARE_6, 0, 0, '0);
        queue_item(OP_DROP, 0, 0, '0);
        queue_item(OP_READ, 1, 0, '0);

        // random: alternate fill and drain so both ends of the list are reached
        filling = 1'b1;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (filling)
                op = roll < 55 ? OP_APPEND : roll < 65 ? OP_OVERWRITE : roll < 70 ? OP_DROP :
                     roll < 78 ? OP_REMOVE : roll < 88 ? OP_READ : roll < 98 ? OP_SWAP :
                     roll < 99 ? OP_SPARE_6 : OP_SPARE_7;
            else
                op = roll < 10 ? OP_APPEND : roll < 18 ? OP_OVERWRITE : roll < 48 ? OP_DROP :
                     roll < 78 ? OP_REMOVE : roll < 88 ? OP_READ : roll < 98 ? OP_SWAP :
                     roll < 99 ? OP_SPARE_6 : OP_SPARE_7;
            queue_item(op, pick_pos(gen_count), pick_pos(gen_count), pick_word(),
                       n == 0 || n == RANDOM_ITEMS / 2);
            n++;
            if (filling && gen_count == CAPACITY)
            begin
                queue_item(OP_READ, CAPACITY - 1, 0, '0);
                queue_item(OP_SWAP, 0, CAPACITY - 1, '0);
                queue_item(OP_OVERWRITE, CAPACITY - 1, 0, pick_word());
                queue_item(OP_APPEND, 0, 0, pick_word());
                queue_item(OP_READ, CAPACITY - 1, 0, '0);
                n += 5;
                filling = 1'b0;
            end
            else if (!filling && gen_count == 0)
            begin
                queue_item(OP_DROP, 0, 0, '0);
                queue_item(OP_READ, 0, 0, '0);
                n += 2;
                filling = 1'b1;
            end
        end

        while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_q.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_q.size());
            errors++;
        end

        $display("checked %0d results over %0d requests, %0d of them refused",
                 results_checked, accepted_items, refusals);
        $display("list depth peaked at %0d of %0d entries", peak_count, CAPACITY);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/alist_pkg.sv
hdl/alist_req_if.sv
hdl/alist_rsp_if.sv
hdl/alist_cell.sv
hdl/alist_or_tree.sv
hdl/array_list_engine.sv
tb/tb_array_list_engine.sv
